/* design/pcu8_pkg.sv */
// Shared types, byte constants and a lookup table for the cell-to-UTF-8 encoder.
`timescale 1ns / 1ps

package pcu8_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MODE_W      = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_FULL    = 3'd0,
        MODE_HORIZ   = 3'd1,
        MODE_VERT    = 3'd2,
        MODE_QUAD    = 3'd3,
        MODE_BRAILLE = 3'd4
    } t_mode;

    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam logic [7:0] BYTE_LF        = 8'h0a;
    localparam logic [7:0] BYTE_LEAD3     = 8'he2;
    localparam logic [7:0] BYTE_BLOCK_MID = 8'h96;
    localparam logic [7:0] BYTE_BRL_MID   = 8'ha0;
    localparam logic [7:0] BYTE_CONT      = 8'h80;
    localparam logic [7:0] BYTE_LEAD4     = 8'hf0;
    localparam logic [7:0] BYTE_SXT_2     = 8'h9f;
    localparam logic [7:0] BYTE_SXT_3     = 8'hac;
    localparam logic [7:0] LAST_FULL      = 8'h88;
    localparam logic [7:0] LAST_UPPER     = 8'h80;
    localparam logic [7:0] LAST_LOWER     = 8'h84;
    localparam logic [7:0] LAST_LEFT      = 8'h8c;
    localparam logic [7:0] LAST_RIGHT     = 8'h90;

    localparam int SEXTANT_DIV = 21;

    typedef struct packed {
        logic [7:0] cell_pixels;
        logic       row_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    // One classified character: up to four bytes, byte 0 sent first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
        logic            row_end;
    } t_glyph;

    function automatic logic [7:0] quad_last(input logic [3:0] code);
        logic [7:0] v;
        case (code)
            4'd0:    v = 8'h20;
            4'd1:    v = 8'h97;
            4'd2:    v = 8'h96;
            4'd3:    v = 8'h84;
            4'd4:    v = 8'h9d;
            4'd5:    v = 8'h90;
            4'd6:    v = 8'h9e;
            4'd7:    v = 8'h9f;
            4'd8:    v = 8'h98;
            4'd9:    v = 8'h9a;
            4'd10:   v = 8'h8c;
            4'd11:   v = 8'h99;
            4'd12:   v = 8'h80;
            4'd13:   v = 8'h9c;
            4'd14:   v = 8'h9b;
            default: v = 8'h88;
        endcase
        return v;
    endfunction

endpackage

/* design/pixel_cell_to_utf8_block_encoder.sv */
// The first byte of a request passes through the queue, the character register and the
// byte-wide output register. Throughput: one output byte per cycle while the output is ready;
// a request gives 1 to 5 bytes (character length plus the line feed).
// The queue decouples input acceptance, so requests arrive back to back while bytes drain, until the queue is full.
// Reset is synchronous and active low; it empties the queue and sets r_mode to 0.
`timescale 1ns / 1ps

module pixel_cell_to_utf8_block_encoder #(
    parameter int QUEUE_DEPTH = pcu8_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pcu8_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pcu8_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_data
);

    logic [2:0]       r_mode;
    logic             q_push, q_pop, q_full, q_empty;
    pcu8_pkg::t_glyph q_wr_data, q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pcu8_pkg::MODE_FULL;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    pcu8_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_mode     (r_mode),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_glyph    (q_wr_data)
    );

    pcu8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pcu8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Queue status flags must never both claim full and empty.
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("queue reports full and empty together");

    // A line feed is only ever sent as the closing byte of a request.
    a_lf_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.out_byte == pcu8_pkg::BYTE_LF)) |-> o_out.last_byte)
        else $error("line feed sent before the end of a request");

    // Nothing is presented on the output in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

/* design/pcu8_front.sv */
// Front end: accepts cell requests and turns each into its UTF-8 byte group.
`timescale 1ns / 1ps

module pcu8_front (
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  pcu8_pkg::t_in_item      i_in,
    input  logic [2:0]              i_mode,
    input  logic                    i_q_full,
    output logic                    o_push,
    output pcu8_pkg::t_glyph        o_glyph
);

    logic [7:0] px;
    logic [5:0] sxt;
    logic [1:0] sxt_q;
    logic       sxt_exact;
    logic [5:0] sxt_idx;
    logic [7:0] brl;
    logic [1:0] sel;
    logic [7:0] blk_last;
    logic       blk_space;
    pcu8_pkg::t_glyph g;

    assign px  = i_in.cell_pixels;
    assign sxt = px[5:0];

    // Quotient by 21 for a six-bit value is a three-way compare.
    always_comb begin
        if (sxt >= 6'(3 * pcu8_pkg::SEXTANT_DIV)) begin
            sxt_q = 2'd3;
        end else if (sxt >= 6'(2 * pcu8_pkg::SEXTANT_DIV)) begin
            sxt_q = 2'd2;
        end else if (sxt >= 6'(pcu8_pkg::SEXTANT_DIV)) begin
            sxt_q = 2'd1;
        end else begin
            sxt_q = 2'd0;
        end
    end

    assign sxt_exact = (sxt == 6'd0) || (sxt == 6'(pcu8_pkg::SEXTANT_DIV))
                    || (sxt == 6'(2 * pcu8_pkg::SEXTANT_DIV))
                    || (sxt == 6'(3 * pcu8_pkg::SEXTANT_DIV));
    assign sxt_idx = sxt - 6'(sxt_q) - 6'd1;

    assign brl = {px[7], px[6], px[5], px[3], px[1], px[4], px[2], px[0]};

    // Two-bit shape code and last byte for the modes that share the block layout.
    always_comb begin
        sel      = 2'd0;
        blk_last = pcu8_pkg::LAST_FULL;
        case (i_mode)
            pcu8_pkg::MODE_FULL: begin
                sel = px[0] ? 2'd3 : 2'd0;
            end
            pcu8_pkg::MODE_HORIZ: begin
                sel = {px[0], px[2]};
                case (sel)
                    2'd1:    blk_last = pcu8_pkg::LAST_LOWER;
                    2'd2:    blk_last = pcu8_pkg::LAST_UPPER;
                    default: blk_last = pcu8_pkg::LAST_FULL;
                endcase
            end
            pcu8_pkg::MODE_VERT: begin
                sel = {px[0], px[1]};
                case (sel)
                    2'd1:    blk_last = pcu8_pkg::LAST_RIGHT;
                    2'd2:    blk_last = pcu8_pkg::LAST_LEFT;
                    default: blk_last = pcu8_pkg::LAST_FULL;
                endcase
            end
            pcu8_pkg::MODE_QUAD: begin
                sel      = (px[3:0] != 4'd0) ? 2'd3 : 2'd0;
                blk_last = pcu8_pkg::quad_last({px[0], px[1], px[2], px[3]});
            end
            default: begin
                sel = sxt_q;
                case (sxt_q)
                    2'd1:    blk_last = pcu8_pkg::LAST_LEFT;
                    2'd2:    blk_last = pcu8_pkg::LAST_RIGHT;
                    default: blk_last = pcu8_pkg::LAST_FULL;
                endcase
            end
        endcase
    end

    assign blk_space = (sel == 2'd0);

    always_comb begin
        g.row_end = i_in.row_end;
        g.bytes   = '0;
        g.len     = 3'd1;
        if (i_mode == pcu8_pkg::MODE_BRAILLE) begin
            g.bytes[0] = pcu8_pkg::BYTE_LEAD3;
            g.bytes[1] = pcu8_pkg::BYTE_BRL_MID | {6'd0, brl[7:6]};
            g.bytes[2] = pcu8_pkg::BYTE_CONT | {2'd0, brl[5:0]};
            g.len      = 3'd3;
        end else if ((i_mode > pcu8_pkg::MODE_BRAILLE) && !sxt_exact) begin
            g.bytes[0] = pcu8_pkg::BYTE_LEAD4;
            g.bytes[1] = pcu8_pkg::BYTE_SXT_2;
            g.bytes[2] = pcu8_pkg::BYTE_SXT_3;
            g.bytes[3] = pcu8_pkg::BYTE_CONT | {2'd0, sxt_idx};
            g.len      = 3'd4;
        end else if (blk_space) begin
            g.bytes[0] = pcu8_pkg::BYTE_SPACE;
            g.len      = 3'd1;
        end else begin
            g.bytes[0] = pcu8_pkg::BYTE_LEAD3;
            g.bytes[1] = pcu8_pkg::BYTE_BLOCK_MID;
            g.bytes[2] = blk_last;
            g.len      = 3'd3;
        end
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_glyph    = g;

endmodule

/* design/pcu8_queue.sv */
// Small FIFO of classified characters between the front and back ends.
`timescale 1ns / 1ps

module pcu8_queue #(
    parameter int DEPTH = pcu8_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcu8_pkg::t_glyph i_data,
    input  logic             i_pop,
    output pcu8_pkg::t_glyph o_head,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcu8_pkg::t_glyph r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* design/pcu8_back.sv */
// Back end: sends one character's bytes, then the optional line feed, one per cycle while the output is ready.
`timescale 1ns / 1ps

module pcu8_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcu8_pkg::t_glyph     i_head,
    input  logic                 i_q_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pcu8_pkg::t_out_item  o_out
);

    pcu8_pkg::t_glyph    r_cur;
    logic                r_busy, n_busy;
    logic [2:0]          r_idx, n_idx;
    logic [2:0]          r_total;
    logic                r_out_valid;
    pcu8_pkg::t_out_item r_out;
    logic                out_free;
    logic                emit;
    logic                is_last;
    logic                pop;
    logic [7:0]          cur_byte;

    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = r_busy && out_free;
    assign is_last  = (r_idx == r_total - 3'd1);
    // The next character is loaded as the last byte of the current one leaves.
    assign pop      = !i_q_empty && (!r_busy || (emit && is_last));
    assign cur_byte = (r_idx < r_cur.len) ? r_cur.bytes[r_idx[1:0]] : pcu8_pkg::BYTE_LF;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (emit) begin
            n_idx = r_idx + 3'd1;
            if (is_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur   <= i_head;
            r_total <= i_head.len + {2'd0, i_head.row_end};
        end
        if (emit) begin
            r_out.out_byte  <= cur_byte;
            r_out.last_byte <= is_last;
        end
    end

    assign o_pop       = pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
